[rtl/core/tgr_pkg.sv]
// ----------------------------------------------------------------------------
// Touch gesture recognizer package
// Shared types, codes and constants of the touch gesture recognizer.
// ----------------------------------------------------------------------------
package tgr_pkg;

  localparam int unsigned MAX_RES = 3;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CFG_W   = 33;

  localparam logic [15:0] FULL_COORD = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_FINGER = 2'd0,
    ACT_MULTI  = 2'd1,
    ACT_TICK   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    BTN_NONE  = 2'd0,
    BTN_LEFT  = 2'd1,
    BTN_RIGHT = 2'd2
  } button_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_NEAR_ZONE    = 3'd0,
    CFG_MULTI_QUIET  = 3'd1,
    CFG_DOUBLE_CLICK = 3'd2,
    CFG_LONG_PRESS   = 3'd3,
    CFG_LIFT_DELAY   = 3'd4,
    CFG_DRAG_DELAY   = 3'd5,
    CFG_ROTATION     = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [32:0] near_zone_squared;
    logic [15:0] multi_quiet_ms;
    logic [15:0] double_click_ms;
    logic [15:0] long_press_ms;
    logic [15:0] lift_delay_ms;
    logic [15:0] drag_delay_ms;
    logic [2:0]  rotation_mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [15:0] touch_x;
    logic [15:0] touch_y;
    logic [7:0]  contact_id;
    logic        tip_down;
  } item_t;

  typedef struct packed {
    logic [1:0]  button;
    logic [15:0] pointer_x;
    logic [15:0] pointer_y;
    logic [7:0]  pointer_id;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]     count;
    res_t [MAX_RES-1:0]   res;
  } res_bundle_t;

endpackage

[rtl/core/tgr_near.sv]
// ----------------------------------------------------------------------------
// Touch gesture recognizer closeness test
// Tells whether the squared distance of two points lies below the near zone.
// ----------------------------------------------------------------------------
module tgr_near (
  input  logic [15:0] ax,
  input  logic [15:0] ay,
  input  logic [15:0] bx,
  input  logic [15:0] by,
  input  logic [32:0] near_zone_squared,
  output logic        close
);

  logic [15:0] dx;
  logic [15:0] dy;
  logic [31:0] sqx;
  logic [31:0] sqy;
  logic [32:0] sum;

  assign dx    = (ax >= bx) ? (ax - bx) : (bx - ax);
  assign dy    = (ay >= by) ? (ay - by) : (by - ay);
  assign sqx   = dx * dx;
  assign sqy   = dy * dy;
  assign sum   = {1'b0, sqx} + {1'b0, sqy};
  assign close = (sum < near_zone_squared);

endmodule

[rtl/core/tgr_core.sv]
// ----------------------------------------------------------------------------
// Touch gesture recognizer core
// Holds the gesture state and turns one item into up to three pointer events.
// ----------------------------------------------------------------------------
module tgr_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 proc_en,
  input  tgr_pkg::item_t       item,
  input  tgr_pkg::cfg_t        cfg,
  output tgr_pkg::res_bundle_t bundle
);

  typedef struct packed {
    logic        finger_down;
    logic        right_clicking;
    logic        moved_in_right_click;
    logic        dragging;
    logic        drag_pending;
    logic        lift_armed;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [31:0] start_time;
    logic [15:0] click_x;
    logic [15:0] click_y;
    logic [31:0] click_time;
    logic [15:0] recent_x;
    logic [15:0] recent_y;
    logic [7:0]  recent_id;
    logic [31:0] multi_time;
    logic [31:0] lift_deadline;
    logic [31:0] drag_deadline;
  } state_t;

  state_t st_r;
  state_t st_nxt;

  logic [15:0] rx;
  logic [15:0] ry;
  logic        near_click;
  logic        rot_near_start;
  logic        click_near_start;

  always_comb begin
    rx = cfg.rotation_mode[0] ? item.touch_y : item.touch_x;
    ry = cfg.rotation_mode[0] ? item.touch_x : item.touch_y;
    if (cfg.rotation_mode[1]) begin
      rx = tgr_pkg::FULL_COORD - rx;
    end
    if (cfg.rotation_mode[2]) begin
      ry = tgr_pkg::FULL_COORD - ry;
    end
  end

  tgr_near u_near_click (
    .ax(rx), .ay(ry), .bx(st_r.click_x), .by(st_r.click_y),
    .near_zone_squared(cfg.near_zone_squared), .close(near_click)
  );

  tgr_near u_near_start (
    .ax(rx), .ay(ry), .bx(st_r.start_x), .by(st_r.start_y),
    .near_zone_squared(cfg.near_zone_squared), .close(rot_near_start)
  );

  tgr_near u_near_snap (
    .ax(st_r.click_x), .ay(st_r.click_y), .bx(st_r.start_x), .by(st_r.start_y),
    .near_zone_squared(cfg.near_zone_squared), .close(click_near_start)
  );

  always_comb begin
    logic [31:0]             d_multi;
    logic [31:0]             d_click;
    logic [31:0]             d_start;
    logic [31:0]             d_drag;
    logic [31:0]             d_lift;
    logic [31:0]             d_order;
    logic                    snap;
    logic                    near_start;
    logic                    long_press;
    logic                    drag_due;
    logic                    lift_due;
    logic [15:0]             px;
    logic [15:0]             py;
    logic [tgr_pkg::CNT_W-1:0] k;
    tgr_pkg::res_t [tgr_pkg::MAX_RES-1:0] res;

    st_nxt     = st_r;
    res        = '0;
    k          = '0;
    d_multi    = item.now_ms - st_r.multi_time;
    d_click    = item.now_ms - st_r.click_time;
    d_start    = item.now_ms - st_r.start_time;
    d_drag     = item.now_ms - st_r.drag_deadline;
    d_lift     = item.now_ms - st_r.lift_deadline;
    d_order    = st_r.lift_deadline - st_r.drag_deadline;
    snap       = near_click && (d_click <= {16'd0, cfg.double_click_ms});
    near_start = snap ? click_near_start : rot_near_start;
    long_press = !st_r.right_clicking && near_start &&
                 (d_start >= {16'd0, cfg.long_press_ms});
    px         = snap ? st_r.click_x : rx;
    py         = snap ? st_r.click_y : ry;
    drag_due   = st_r.drag_pending && !st_r.dragging && !d_drag[31];
    lift_due   = st_r.lift_armed && !d_lift[31];
    if (drag_due && lift_due && d_order[31]) begin
      drag_due = 1'b0;
    end

    unique case (item.action)
      tgr_pkg::ACT_FINGER: begin
        if (!(d_multi < {16'd0, cfg.multi_quiet_ms}) && item.tip_down) begin
          if (!st_r.finger_down) begin
            st_nxt.finger_down = 1'b1;
            st_nxt.start_time  = item.now_ms;
            st_nxt.start_x     = px;
            st_nxt.start_y     = py;
          end else if (!st_r.dragging) begin
            if (long_press) begin
              res[k] = '{tgr_pkg::BTN_RIGHT, px, py, item.contact_id, 1'b0};
              k      = k + 1'b1;
              res[k] = '{tgr_pkg::BTN_NONE, px, py, item.contact_id, 1'b0};
              k      = k + 1'b1;
              st_nxt.right_clicking = 1'b1;
            end
            if (st_r.right_clicking || long_press) begin
              if (near_start) begin
                px = st_r.start_x;
                py = st_r.start_y;
              end else begin
                st_nxt.moved_in_right_click = 1'b1;
              end
            end else if (!st_r.drag_pending && !near_start) begin
              st_nxt.drag_pending  = 1'b1;
              st_nxt.drag_deadline = item.now_ms + {16'd0, cfg.drag_delay_ms};
            end
          end
          res[k] = '{(st_r.dragging ? tgr_pkg::BTN_LEFT : tgr_pkg::BTN_NONE),
                     px, py, item.contact_id, 1'b0};
          k      = k + 1'b1;
          st_nxt.recent_x      = px;
          st_nxt.recent_y      = py;
          st_nxt.recent_id     = item.contact_id;
          st_nxt.lift_armed    = 1'b1;
          st_nxt.lift_deadline = item.now_ms + {16'd0, cfg.lift_delay_ms};
        end
      end
      tgr_pkg::ACT_MULTI: begin
        st_nxt.lift_armed           = 1'b0;
        st_nxt.finger_down          = 1'b0;
        st_nxt.right_clicking       = 1'b0;
        st_nxt.moved_in_right_click = 1'b0;
        st_nxt.dragging             = 1'b0;
        st_nxt.drag_pending         = 1'b0;
        st_nxt.multi_time           = item.now_ms;
      end
      tgr_pkg::ACT_TICK: begin
        if (drag_due) begin
          res[k] = '{tgr_pkg::BTN_LEFT, st_r.start_x, st_r.start_y, st_r.recent_id, 1'b0};
          k      = k + 1'b1;
          st_nxt.dragging = 1'b1;
        end
        if (lift_due) begin
          if (!(st_r.dragging || drag_due) &&
              (!st_r.right_clicking || st_r.moved_in_right_click)) begin
            res[k] = '{tgr_pkg::BTN_LEFT, st_r.recent_x, st_r.recent_y,
                       st_r.recent_id, 1'b0};
            k      = k + 1'b1;
          end
          res[k] = '{tgr_pkg::BTN_NONE, st_r.recent_x, st_r.recent_y,
                     st_r.recent_id, 1'b0};
          k      = k + 1'b1;
          st_nxt.click_x              = st_r.recent_x;
          st_nxt.click_y              = st_r.recent_y;
          st_nxt.click_time           = item.now_ms;
          st_nxt.finger_down          = 1'b0;
          st_nxt.right_clicking       = 1'b0;
          st_nxt.moved_in_right_click = 1'b0;
          st_nxt.dragging             = 1'b0;
          st_nxt.drag_pending         = 1'b0;
          st_nxt.lift_armed           = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (k != '0) begin
      res[k - 1'b1].last = 1'b1;
    end
    bundle.count = k;
    bundle.res   = res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (proc_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

[rtl/core/tgr_out_buf.sv]
// ----------------------------------------------------------------------------
// Touch gesture recognizer result buffer
// Holds the events of one item and hands them out one transaction at a time.
// ----------------------------------------------------------------------------
module tgr_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  tgr_pkg::res_bundle_t bundle,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output tgr_pkg::res_t        head,
  output logic                 free
);

  tgr_pkg::res_t [tgr_pkg::MAX_RES-1:0] res_r;
  logic [tgr_pkg::CNT_W-1:0]            cnt_r;

  assign out_tvalid = (cnt_r != '0);
  assign head       = res_r[0];
  assign free       = (cnt_r == '0) ||
                      ((cnt_r == tgr_pkg::CNT_W'(1)) && out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= bundle.count;
    end else if (out_tvalid && out_tready) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= bundle.res;
    end else if (out_tvalid && out_tready) begin
      for (int i = 0; i < tgr_pkg::MAX_RES - 1; i++) begin
        res_r[i] <= res_r[i + 1];
      end
    end
  end

endmodule

[rtl/core/touch_gesture_recognizer.sv]
// ----------------------------------------------------------------------------
// Touch gesture recognizer
// Turns finger reports, multi-contact reports and time ticks into pointer
// events with long-press right click, drag detection and lift timing.
//
// Channel  Direction  Handshake         Payload
// in_      slave      tvalid/tready     tuser action, tdata report
// out_     master     tvalid/tready     tuser button, tdata pointer, tlast
// cfg_     write      we                index, wdata
//
// An accepted item waits in the input register until the result buffer is
// free, and is then processed into zero to three events in that buffer.
// Items with one event or none flow at one per cycle while out_tready stays
// high; an item with more events holds the next until all but one are out.
// Reset is synchronous and active low; a stalled output keeps one item
// waiting in the input register before in_tready drops.
// ----------------------------------------------------------------------------
module touch_gesture_recognizer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // now_ms[31:0], touch_x[47:32], touch_y[63:48], contact_id[71:64],
  // tip_down[72], zero fill[79:73]
  input  logic [79:0]               in_tdata,
  // action[1:0]
  input  logic [1:0]                in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // pointer_x[15:0], pointer_y[31:16], pointer_id[39:32]
  output logic [39:0]               out_tdata,
  // button[1:0]
  output logic [1:0]                out_tuser,
  output logic                      out_tlast,
  input  logic                      cfg_we,
  input  logic [tgr_pkg::IDX_W-1:0] cfg_index,
  input  logic [tgr_pkg::CFG_W-1:0] cfg_wdata
);

  tgr_pkg::cfg_t        cfg_r;
  tgr_pkg::item_t       item_r;
  logic                 in_valid_r;
  logic                 proc;
  logic                 buf_free;
  tgr_pkg::res_bundle_t bundle;
  tgr_pkg::res_t        head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_zone_squared <= 33'd1000000;
      cfg_r.multi_quiet_ms    <= 16'd300;
      cfg_r.double_click_ms   <= 16'd500;
      cfg_r.long_press_ms     <= 16'd600;
      cfg_r.lift_delay_ms     <= 16'd100;
      cfg_r.drag_delay_ms     <= 16'd200;
      cfg_r.rotation_mode     <= 3'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgr_pkg::CFG_NEAR_ZONE:    cfg_r.near_zone_squared <= cfg_wdata;
        tgr_pkg::CFG_MULTI_QUIET:  cfg_r.multi_quiet_ms    <= cfg_wdata[15:0];
        tgr_pkg::CFG_DOUBLE_CLICK: cfg_r.double_click_ms   <= cfg_wdata[15:0];
        tgr_pkg::CFG_LONG_PRESS:   cfg_r.long_press_ms     <= cfg_wdata[15:0];
        tgr_pkg::CFG_LIFT_DELAY:   cfg_r.lift_delay_ms     <= cfg_wdata[15:0];
        tgr_pkg::CFG_DRAG_DELAY:   cfg_r.drag_delay_ms     <= cfg_wdata[15:0];
        tgr_pkg::CFG_ROTATION:     cfg_r.rotation_mode     <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  assign proc      = in_valid_r && buf_free;
  assign in_tready = !in_valid_r || buf_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.action     <= in_tuser;
      item_r.now_ms     <= in_tdata[31:0];
      item_r.touch_x    <= in_tdata[47:32];
      item_r.touch_y    <= in_tdata[63:48];
      item_r.contact_id <= in_tdata[71:64];
      item_r.tip_down   <= in_tdata[72];
    end
  end

  tgr_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .proc_en(proc),
    .item   (item_r),
    .cfg    (cfg_r),
    .bundle (bundle)
  );

  tgr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (proc),
    .bundle    (bundle),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .head      (head),
    .free      (buf_free)
  );

  assign out_tdata = {head.pointer_id, head.pointer_y, head.pointer_x};
  assign out_tuser = head.button;
  assign out_tlast = head.last;

  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r)
    else $error("input stalled without a held item");

  a_events_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && (bundle.count != '0)) |=> out_tvalid)
    else $error("processed item lost its events");

  a_more_after_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |=> out_tvalid)
    else $error("event run ended without a final transaction");

  a_tip_up_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && (item_r.action == tgr_pkg::ACT_FINGER) && !item_r.tip_down)
      |-> (bundle.count == '0))
    else $error("finger report without tip produced events");

endmodule

[tb/tb_touch_gesture_recognizer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch gesture recognizer testbench
// Drives finger reports, multi-contact reports and ticks through the stream
// port and predicts every pointer event in a local model of the recognizer.
// A short table of hand-written cases runs first. Random gestures follow
// (taps, double taps, long presses, drags, multi-contact bursts and noise)
// under four register settings and four patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_touch_gesture_recognizer;

  localparam int          PRED           = -1;
  localparam int unsigned PHASE_ITEMS    = 115;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;
  localparam logic [2:0]  CFG_UNUSED_IDX = 3'd7;

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [79:0]               in_tdata;
  logic [1:0]                in_tuser;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [39:0]               out_tdata;
  logic [1:0]                out_tuser;
  logic                      out_tlast;
  logic                      cfg_we;
  logic [tgr_pkg::IDX_W-1:0] cfg_index;
  logic [tgr_pkg::CFG_W-1:0] cfg_wdata;

  touch_gesture_recognizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  tgr_pkg::cfg_t  regs;
  logic           fdown, rclick, rmoved, drag_on, drag_wait, lift_on;
  logic [15:0]    start_px, start_py, click_px, click_py, last_px, last_py;
  logic [7:0]     last_id;
  logic [31:0]    start_ms, click_ms, multi_ms, lift_due_ms, drag_due_ms;

  tgr_pkg::res_t  step_events[$];
  tgr_pkg::res_t  awaited_events[$];

  tgr_pkg::item_t plan_item[$];
  int             plan_n[$];
  tgr_pkg::res_t  plan_ev0[$];
  tgr_pkg::res_t  plan_ev1[$];

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_reqs;
  int unsigned holds_done;
  int unsigned fed;
  int unsigned mismatches;
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------
  function automatic tgr_pkg::res_t pointer_event(tgr_pkg::button_t b, logic [15:0] x,
                                                  logic [15:0] y, logic [7:0] id,
                                                  logic fin);
    tgr_pkg::res_t r;
    r.button     = b;
    r.pointer_x  = x;
    r.pointer_y  = y;
    r.pointer_id = id;
    r.last       = fin;
    return r;
  endfunction

  function automatic bit is_near(logic [15:0] ax, logic [15:0] ay,
                                 logic [15:0] bx, logic [15:0] by);
    longint unsigned dx, dy;
    dx = (ax >= bx) ? longint'(ax - bx) : longint'(bx - ax);
    dy = (ay >= by) ? longint'(ay - by) : longint'(by - ay);
    return (dx * dx + dy * dy) < {31'd0, regs.near_zone_squared};
  endfunction

  function automatic bit is_due(logic [31:0] now, logic [31:0] deadline);
    logic [31:0] d;
    d = now - deadline;
    return !d[31];
  endfunction

  task automatic emit_event(tgr_pkg::button_t b, logic [15:0] x, logic [15:0] y,
                            logic [7:0] id);
    step_events.push_back(pointer_event(b, x, y, id, 1'b0));
  endtask

  task automatic drop_touch();
    fdown     = 1'b0;
    rclick    = 1'b0;
    rmoved    = 1'b0;
    drag_on   = 1'b0;
    drag_wait = 1'b0;
  endtask

  task automatic reset_model();
    regs.near_zone_squared = 33'd1000000;
    regs.multi_quiet_ms    = 16'd300;
    regs.double_click_ms   = 16'd500;
    regs.long_press_ms     = 16'd600;
    regs.lift_delay_ms     = 16'd100;
    regs.drag_delay_ms     = 16'd200;
    regs.rotation_mode     = 3'd0;
    drop_touch();
    lift_on     = 1'b0;
    start_px    = '0;
    start_py    = '0;
    start_ms    = '0;
    click_px    = '0;
    click_py    = '0;
    click_ms    = '0;
    last_px     = '0;
    last_py     = '0;
    last_id     = '0;
    multi_ms    = '0;
    lift_due_ms = '0;
    drag_due_ms = '0;
  endtask

  task automatic track_finger(tgr_pkg::item_t it);
    logic [15:0] x, y, sw;
    logic        near_start;
    x = it.touch_x;
    y = it.touch_y;
    if (it.now_ms - multi_ms < {16'd0, regs.multi_quiet_ms}) return;
    if (!it.tip_down) return;
    if (regs.rotation_mode[0]) begin
      sw = x;
      x  = y;
      y  = sw;
    end
    if (regs.rotation_mode[1]) x = tgr_pkg::FULL_COORD - x;
    if (regs.rotation_mode[2]) y = tgr_pkg::FULL_COORD - y;
    if (is_near(x, y, click_px, click_py) &&
        (it.now_ms - click_ms <= {16'd0, regs.double_click_ms})) begin
      x = click_px;
      y = click_py;
    end
    if (!fdown) begin
      fdown    = 1'b1;
      start_ms = it.now_ms;
      start_px = x;
      start_py = y;
    end else if (!drag_on) begin
      near_start = is_near(x, y, start_px, start_py);
      if (!rclick && near_start &&
          (it.now_ms - start_ms >= {16'd0, regs.long_press_ms})) begin
        emit_event(tgr_pkg::BTN_RIGHT, x, y, it.contact_id);
        emit_event(tgr_pkg::BTN_NONE, x, y, it.contact_id);
        rclick = 1'b1;
      end
      if (rclick) begin
        if (near_start) begin
          x = start_px;
          y = start_py;
        end else begin
          rmoved = 1'b1;
        end
      end else if (!drag_wait && !near_start) begin
        drag_wait   = 1'b1;
        drag_due_ms = it.now_ms + {16'd0, regs.drag_delay_ms};
      end
    end
    emit_event(drag_on ? tgr_pkg::BTN_LEFT : tgr_pkg::BTN_NONE, x, y, it.contact_id);
    last_px     = x;
    last_py     = y;
    last_id     = it.contact_id;
    lift_on     = 1'b1;
    lift_due_ms = it.now_ms + {16'd0, regs.lift_delay_ms};
  endtask

  task automatic run_timers(logic [31:0] now);
    logic fire_drag, fire_lift;
    fire_drag = drag_wait && !drag_on && is_due(now, drag_due_ms);
    fire_lift = lift_on && is_due(now, lift_due_ms);
    // When both are due, a lift deadline strictly earlier than the drag one wins alone.
    if (fire_drag && fire_lift && !is_due(lift_due_ms, drag_due_ms)) fire_drag = 1'b0;
    if (fire_drag) begin
      emit_event(tgr_pkg::BTN_LEFT, start_px, start_py, last_id);
      drag_on = 1'b1;
    end
    if (fire_lift) begin
      if (!drag_on && (!rclick || rmoved)) begin
        emit_event(tgr_pkg::BTN_LEFT, last_px, last_py, last_id);
      end
      emit_event(tgr_pkg::BTN_NONE, last_px, last_py, last_id);
      click_px = last_px;
      click_py = last_py;
      click_ms = now;
      drop_touch();
      lift_on = 1'b0;
    end
  endtask

  task automatic predict(tgr_pkg::item_t it);
    tgr_pkg::res_t tail;
    step_events.delete();
    case (it.action)
      tgr_pkg::ACT_FINGER: track_finger(it);
      tgr_pkg::ACT_MULTI: begin
        lift_on = 1'b0;
        drop_touch();
        multi_ms = it.now_ms;
      end
      tgr_pkg::ACT_TICK: run_timers(it.now_ms);
      default: ;
    endcase
    if (step_events.size() > 0) begin
      tail = step_events.pop_back();
      tail.last = 1'b1;
      step_events.push_back(tail);
    end
  endtask

  // ------------------------------------------------------------------------
  // Driving
  // ------------------------------------------------------------------------
  function automatic tgr_pkg::item_t make_item(logic [1:0] a, logic [31:0] now,
                                               logic [15:0] x, logic [15:0] y,
                                               logic [7:0] id, logic tip);
    tgr_pkg::item_t it;
    it.action     = a;
    it.now_ms     = now;
    it.touch_x    = x;
    it.touch_y    = y;
    it.contact_id = id;
    it.tip_down   = tip;
    return it;
  endfunction

  task automatic send_item(tgr_pkg::item_t it, int typed_n = PRED,
                           tgr_pkg::res_t ev0 = '0, tgr_pkg::res_t ev1 = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = it.action;
    in_tdata  = {7'd0, it.tip_down, it.contact_id, it.touch_y, it.touch_x, it.now_ms};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict(it);
    if (typed_n == PRED) begin
      foreach (step_events[i]) awaited_events.push_back(step_events[i]);
    end else begin
      if (typed_n > 0) awaited_events.push_back(ev0);
      if (typed_n > 1) awaited_events.push_back(ev1);
    end
    if (it.action != ACT_UNUSED && !(it.action == tgr_pkg::ACT_FINGER && !it.tip_down)) fed++;
    @(negedge clk);
  endtask

  task automatic put_reg(logic [tgr_pkg::IDX_W-1:0] idx, logic [tgr_pkg::CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
  endtask

  task automatic program_regs(logic [32:0] near, logic [15:0] quiet, logic [15:0] dbl,
                              logic [15:0] press, logic [15:0] lift, logic [15:0] drag,
                              logic [2:0] rot);
    put_reg(tgr_pkg::CFG_NEAR_ZONE, near);
    put_reg(tgr_pkg::CFG_MULTI_QUIET, {17'd0, quiet});
    put_reg(tgr_pkg::CFG_DOUBLE_CLICK, {17'd0, dbl});
    put_reg(tgr_pkg::CFG_LONG_PRESS, {17'd0, press});
    put_reg(tgr_pkg::CFG_LIFT_DELAY, {17'd0, lift});
    put_reg(tgr_pkg::CFG_DRAG_DELAY, {17'd0, drag});
    put_reg(tgr_pkg::CFG_ROTATION, {30'd0, rot});
    put_reg(CFG_UNUSED_IDX, 33'($urandom));
    cfg_we = 1'b0;
    regs.near_zone_squared = near;
    regs.multi_quiet_ms    = quiet;
    regs.double_click_ms   = dbl;
    regs.long_press_ms     = press;
    regs.lift_delay_ms     = lift;
    regs.drag_delay_ms     = drag;
    regs.rotation_mode     = rot;
  endtask

  task automatic settle();
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_row(tgr_pkg::item_t it, int n, tgr_pkg::res_t ev0 = '0,
                         tgr_pkg::res_t ev1 = '0);
    plan_item.push_back(it);
    plan_n.push_back(n);
    plan_ev0.push_back(ev0);
    plan_ev1.push_back(ev1);
  endtask

  // ------------------------------------------------------------------------
  // Random gestures
  // ------------------------------------------------------------------------
  task automatic pass_ms(int unsigned lo, int unsigned hi);
    clock_ms += $urandom_range(hi, lo);
  endtask

  function automatic logic [15:0] wobble(logic [15:0] v, int unsigned amt);
    logic [15:0] d;
    d = 16'($urandom_range(2 * amt));
    return v + d - amt[15:0];
  endfunction

  task automatic touch_at(logic [15:0] x, logic [15:0] y, logic [7:0] id);
    send_item(make_item(tgr_pkg::ACT_FINGER, clock_ms, x, y, id, 1'b1));
  endtask

  task automatic tick_now();
    send_item(make_item(tgr_pkg::ACT_TICK, clock_ms, 16'($urandom), 16'($urandom),
                        8'($urandom), 1'($urandom)));
  endtask

  task automatic wait_lift();
    pass_ms(0, regs.lift_delay_ms / 2);
    tick_now();
    pass_ms(regs.lift_delay_ms, regs.lift_delay_ms + 20);
    tick_now();
  endtask

  task automatic gesture();
    logic [15:0] gx, gy;
    logic [7:0]  gid;
    logic [1:0]  act;
    int unsigned kind, n, span;
    gx   = 16'($urandom);
    gy   = 16'($urandom);
    gid  = 8'($urandom);
    kind = $urandom_range(99);
    if (kind < 22) begin
      n = $urandom_range(3, 1);
      repeat (n) begin
        touch_at(wobble(gx, 30), wobble(gy, 30), gid);
        pass_ms(5, 40);
      end
      wait_lift();
    end else if (kind < 42) begin
      span = regs.long_press_ms + $urandom_range(300);
      n    = $urandom_range(8, 4);
      touch_at(gx, gy, gid);
      repeat (n) begin
        pass_ms(span / n, span / n + 10);
        if ($urandom_range(3) == 0) tick_now();
        touch_at(wobble(gx, 30), wobble(gy, 30), gid);
      end
      if ($urandom_range(1) == 1) begin
        pass_ms(5, 30);
        touch_at(gx ^ 16'h8000, gy, gid);
      end
      wait_lift();
    end else if (kind < 64) begin
      touch_at(gx, gy, gid);
      n = $urandom_range(8, 3);
      repeat (n) begin
        pass_ms(5, regs.lift_delay_ms / 2 + 10);
        gx = wobble(gx, 6000);
        gy = wobble(gy, 6000);
        if ($urandom_range(1) == 1) tick_now();
        touch_at(gx, gy, gid);
      end
      wait_lift();
    end else if (kind < 74) begin
      send_item(make_item(tgr_pkg::ACT_MULTI, clock_ms, 16'($urandom), 16'($urandom),
                          8'($urandom), 1'($urandom)));
      n = $urandom_range(3, 1);
      repeat (n) begin
        pass_ms(5, regs.multi_quiet_ms / 2 + 5);
        touch_at(wobble(gx, 50), wobble(gy, 50), gid);
      end
      pass_ms(regs.multi_quiet_ms, regs.multi_quiet_ms + 40);
      touch_at(gx, gy, gid);
      wait_lift();
    end else if (kind < 88) begin
      touch_at(gx, gy, gid);
      pass_ms(5, 30);
      wait_lift();
      pass_ms(0, regs.double_click_ms + 40);
      touch_at(wobble(gx, 300), wobble(gy, 300), gid);
      wait_lift();
    end else begin
      n = $urandom_range(3, 1);
      repeat (n) begin
        if ($urandom_range(4) == 0) clock_ms = $urandom;
        else pass_ms(0, 50);
        act = 2'($urandom_range(3));
        send_item(make_item(act, clock_ms, 16'($urandom), 16'($urandom), 8'($urandom),
                            1'($urandom)));
      end
    end
    pass_ms(0, 150);
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall, bit squeeze);
    send_idle_pct = idle;
    stall_pct     = stall;
    fed           = 0;
    if (squeeze) hold_reqs++;
    while (fed < PHASE_ITEMS) gesture();
    in_tvalid = 1'b0;
    settle();
  endtask

  // ------------------------------------------------------------------------
  // Receiver
  // ------------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      out_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    tgr_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_events.size() == 0) begin
        $error("unexpected event: button %0d x %0d y %0d id %0d last %0d",
               out_tuser, out_tdata[15:0], out_tdata[31:16], out_tdata[39:32], out_tlast);
        mismatches++;
      end else begin
        want = awaited_events.pop_front();
        if (out_tuser !== want.button) begin
          $error("button: expected %0d, got %0d", want.button, out_tuser);
          mismatches++;
        end
        if (out_tdata[15:0] !== want.pointer_x) begin
          $error("pointer_x: expected %0d, got %0d", want.pointer_x, out_tdata[15:0]);
          mismatches++;
        end
        if (out_tdata[31:16] !== want.pointer_y) begin
          $error("pointer_y: expected %0d, got %0d", want.pointer_y, out_tdata[31:16]);
          mismatches++;
        end
        if (out_tdata[39:32] !== want.pointer_id) begin
          $error("pointer_id: expected %0d, got %0d", want.pointer_id, out_tdata[39:32]);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = tgr_pkg::ACT_FINGER;
    cfg_we        = 1'b0;
    cfg_index     = tgr_pkg::CFG_NEAR_ZONE;
    cfg_wdata     = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_reqs     = 0;
    mismatches    = 0;
    fed           = 0;
    clock_ms      = '0;
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    add_row(make_item(tgr_pkg::ACT_FINGER, 32'd100, 16'd1234, 16'd4321, 8'd1, 1'b1), 0);
    add_row(make_item(ACT_UNUSED, 32'd1000, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1), 0);
    add_row(make_item(tgr_pkg::ACT_TICK, 32'd1000, 16'd0, 16'd0, 8'd0, 1'b0), 0);
    add_row(make_item(tgr_pkg::ACT_FINGER, 32'd1000, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1), 1,
            pointer_event(tgr_pkg::BTN_NONE, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));
    add_row(make_item(tgr_pkg::ACT_FINGER, 32'd1050, 16'd0, 16'd0, 8'd0, 1'b0), 0);
    add_row(make_item(tgr_pkg::ACT_TICK, 32'd1099, 16'd0, 16'd0, 8'd0, 1'b0), 0);
    add_row(make_item(tgr_pkg::ACT_TICK, 32'd1100, 16'd0, 16'd0, 8'd0, 1'b0), 2,
            pointer_event(tgr_pkg::BTN_LEFT, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0),
            pointer_event(tgr_pkg::BTN_NONE, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));
    add_row(make_item(tgr_pkg::ACT_FINGER, 32'd1200, 16'd65000, 16'd65000, 8'd7, 1'b1), PRED);
    add_row(make_item(tgr_pkg::ACT_FINGER, 32'd1900, 16'hFFFF, 16'hFFFF, 8'd7, 1'b1), PRED);
    add_row(make_item(tgr_pkg::ACT_FINGER, 32'd1950, 16'd0, 16'd0, 8'd0, 1'b1), PRED);
    add_row(make_item(tgr_pkg::ACT_TICK, 32'd2050, 16'd0, 16'd0, 8'd0, 1'b0), PRED);
    add_row(make_item(tgr_pkg::ACT_MULTI, 32'd3000, 16'd0, 16'd0, 8'd0, 1'b0), 0);
    add_row(make_item(tgr_pkg::ACT_FINGER, 32'd3299, 16'd500, 16'd500, 8'd3, 1'b1), 0);
    add_row(make_item(tgr_pkg::ACT_FINGER, 32'd3300, 16'd1000, 16'd1000, 8'd3, 1'b1), PRED);
    add_row(make_item(tgr_pkg::ACT_FINGER, 32'd3350, 16'd5000, 16'd5000, 8'd3, 1'b1), PRED);
    add_row(make_item(tgr_pkg::ACT_FINGER, 32'd3500, 16'd5000, 16'd5000, 8'd3, 1'b1), PRED);
    add_row(make_item(tgr_pkg::ACT_TICK, 32'd3560, 16'd0, 16'd0, 8'd0, 1'b0), PRED);
    add_row(make_item(tgr_pkg::ACT_FINGER, 32'd3600, 16'd6000, 16'd6000, 8'd3, 1'b1), PRED);
    add_row(make_item(tgr_pkg::ACT_TICK, 32'd3700, 16'd0, 16'd0, 8'd0, 1'b0), PRED);
    add_row(make_item(tgr_pkg::ACT_FINGER, 32'd5000, 16'd100, 16'd100, 8'd9, 1'b1), PRED);
    add_row(make_item(tgr_pkg::ACT_FINGER, 32'd5050, 16'd20000, 16'd20000, 8'd9, 1'b1), PRED);
    add_row(make_item(tgr_pkg::ACT_TICK, 32'd5300, 16'd0, 16'd0, 8'd0, 1'b0), PRED);
    add_row(make_item(tgr_pkg::ACT_FINGER, 32'd6000, 16'd100, 16'd100, 8'd9, 1'b1), PRED);
    add_row(make_item(tgr_pkg::ACT_FINGER, 32'd6010, 16'd30000, 16'd30000, 8'd9, 1'b1), PRED);
    add_row(make_item(tgr_pkg::ACT_FINGER, 32'd6150, 16'd30000, 16'd30000, 8'd9, 1'b1), PRED);
    add_row(make_item(tgr_pkg::ACT_TICK, 32'd6300, 16'd0, 16'd0, 8'd0, 1'b0), PRED);
    foreach (plan_item[i]) send_item(plan_item[i], plan_n[i], plan_ev0[i], plan_ev1[i]);

    clock_ms = 32'd10000;
    run_phase(0, 0, 1'b1);

    program_regs(33'h1_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7);
    clock_ms = $urandom;
    run_phase(49, 0, 1'b0);

    program_regs(33'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 3'($urandom_range(6, 1)));
    clock_ms = $urandom;
    run_phase(0, 49, 1'b0);

    program_regs(33'($urandom_range(32'h0100_0000)), 16'($urandom_range(400)),
                 16'($urandom_range(800)), 16'($urandom_range(800, 50)),
                 16'($urandom_range(150, 20)), 16'($urandom_range(300)),
                 3'($urandom_range(7)));
    clock_ms = 32'hFFFF_F000;
    run_phase(37, 37, 1'b0);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
